// ----- design/mvm_pkg.sv -----
// Package for the matrix-vector multiply-accumulate core.
// Field widths, command and status codes, controller states.
// No dependencies.
package mvm_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CFG_W    = 11;
    localparam int VAL_W    = 32;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int FRAC_W   = 16;
    localparam int SUM_W    = 48;
    localparam int STAT_W   = 2;
    localparam int ENTRY_W  = SUM_W + 1;   // sum plus saturated flag

    localparam int IN_DATA_W  = 80;        // row, matrix, vector, zero fill
    localparam int OUT_DATA_W = 64;        // row, sum, zero fill

    localparam logic CMD_MAC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(MAX_ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } mvm_state_t;

endpackage

// ----- design/matrix_vector_mac_core.sv -----
// Matrix-vector multiply-accumulate core: per-row 48-bit sum store.
// Depends on mvm_pkg (widths, codes, state type).
//
// Usage: after reset the core sweeps its 1024-entry row store to zero, one
// entry per cycle, holding s_tready low until the sweep is done (config
// writes are taken throughout). Each input item is then read from the row
// store (the Q32.32 product is registered in the same cycle) and then
// added, saturated and written back, so the core takes no new item until
// the last one is written back. A read or error result waits in the
// output register, and the core holds in its write-back state only while
// that register is still full. A multiply
// item (tuser = 0) adds floor(matrix * vector / 2^16) into the row sum,
// clamped to the signed 48-bit range with a sticky saturated flag; a read
// item (tuser = 1) returns the sum and flag and clears both. Rows at or
// beyond rows_in_use give status 1 with a zero sum and change nothing.
module matrix_vector_mac_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration: rows_in_use
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mvm_pkg::CFG_W-1:0]        cfg_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [9:0] row_index, [41:10] matrix_value, [73:42] vector_value, [79:74] zero
    input  logic [mvm_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] command
    input  logic                             s_tuser,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] result_row, [57:10] row_sum, [63:58] zero
    output logic [mvm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [mvm_pkg::STAT_W-1:0]       m_tuser
);
    import mvm_pkg::*;

    // controller
    mvm_state_t              state_reg, state_next;
    logic [ROW_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]        rows_in_use_reg;

    // item held from capture through write-back
    logic                    cmd_reg;
    logic [ROW_W-1:0]        row_reg;
    logic                    in_range_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]        out_row_reg;
    logic [SUM_W-1:0]        out_sum_reg;
    logic [STAT_W-1:0]       out_stat_reg;

    // row store: {saturated flag, sum}
    logic [ENTRY_W-1:0]      mem [0:MAX_ROWS-1];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    mem_we;
    logic [ROW_W-1:0]        mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;

    logic                    accept;
    logic [ROW_W-1:0]        in_row;
    logic signed [VAL_W-1:0] in_mat;
    logic signed [VAL_W-1:0] in_vec;
    logic                    in_range;

    logic                    out_free;
    logic                    need_result;
    logic                    load_out;
    logic signed [SUM_W-1:0] q_val;
    logic signed [SUM_W:0]   sum_wide;
    logic                    ovf;
    logic [SUM_W-1:0]        sum_sat;
    logic [SUM_W-1:0]        rd_sum;
    logic                    rd_flag;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign in_row = s_tdata[ROW_W-1:0];
    assign in_mat = s_tdata[ROW_W +: VAL_W];
    assign in_vec = s_tdata[ROW_W+VAL_W +: VAL_W];
    // row is ROW_W bits, so it is always below MAX_ROWS; only rows_in_use limits
    assign in_range = ({1'b0, in_row} < rows_in_use_reg);

    assign rd_sum  = rd_data_reg[SUM_W-1:0];
    assign rd_flag = rd_data_reg[SUM_W];

    // floor shift of the Q32.32 product gives Q32.16
    assign q_val    = prod_reg[PROD_W-1:FRAC_W];
    assign sum_wide = {rd_sum[SUM_W-1], rd_sum} + {q_val[SUM_W-1], q_val};
    assign ovf      = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    always_comb
    begin
        if (!ovf)
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        else if (sum_wide[SUM_W])
        begin
            sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    assign out_free    = !m_valid_reg || m_tready;
    assign need_result = !in_range_reg || (cmd_reg == CMD_READ);
    assign load_out    = (state_reg == ST_EXEC) && need_result && out_free;

    // controller and write port
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = row_reg;
        mem_wdata    = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!need_result || out_free)
                begin
                    state_next = ST_IDLE;
                    if (in_range_reg)
                    begin
                        mem_we = 1'b1;
                        // read clears the entry; accumulate writes sum and sticky flag
                        if (cmd_reg == CMD_MAC)
                        begin
                            mem_wdata = {rd_flag | ovf, sum_sat};
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_tvalid && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            rows_in_use_reg <= ROWS_RESET;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                rows_in_use_reg <= cfg_data;
            end
        end
    end

    // item capture; product registered alongside the store read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= s_tuser;
            row_reg      <= in_row;
            in_range_reg <= in_range;
            prod_reg     <= in_mat * in_vec;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg <= row_reg;
            if (!in_range_reg)
            begin
                out_sum_reg  <= '0;
                out_stat_reg <= STAT_RANGE;
            end
            else
            begin
                out_sum_reg  <= rd_sum;
                out_stat_reg <= rd_flag ? STAT_SAT : STAT_OK;
            end
        end
    end

    // row store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[in_row];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-SUM_W-ROW_W){1'b0}}, out_sum_reg, out_row_reg};
    assign m_tuser  = out_stat_reg;

endmodule
